// ----- src/uer_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_pkg
// shared types, constants and helpers for the ultrasonic echo ranger
// ----------------------------------------------------------------------------
package uer_pkg;

  // tick counter width
  localparam int COUNT_BITS = 17;
  localparam longint CNT_MAX = (64'd1 << COUNT_BITS) - 64'd1;

  // echo width to centimetres: 17 cm per 1000 ticks, kept as a running fraction
  localparam int CM_NUM = 17;
  localparam int CM_DEN = 1000;
  localparam int FRAC_BITS = $clog2(CM_DEN);
  localparam longint DIST_MAX = (CNT_MAX * CM_NUM) / CM_DEN;
  localparam int DIST_BITS = $clog2(DIST_MAX + 64'd1) > 10 ? $clog2(DIST_MAX + 64'd1) : 10;

  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 17;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [FRAC_BITS-1:0] frac_t;
  typedef logic [DIST_BITS-1:0] dist_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_PRE_LOW     = 3'd0,
    CFG_TRIGGER     = 3'd1,
    CFG_WAIT_LIMIT  = 3'd2,
    CFG_HIGH_LIMIT  = 3'd3,
    CFG_MAX_DIST    = 3'd4,
    CFG_THRESHOLD   = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_PRE_LOW,
    PH_TRIG,
    PH_WAIT,
    PH_MEAS
  } phase_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_ECHO  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] pre_low_ticks;
    logic [15:0] trigger_ticks;
    logic [16:0] echo_wait_limit;
    logic [16:0] echo_high_limit;
    logic [9:0]  max_distance;
    logic [9:0]  change_threshold;
  } cfg_t;

  typedef struct packed {
    logic kind;
    logic echo_level;
  } in_item_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    status_t     status;
    logic [9:0]  range_cm;
    logic        changed;
  } out_item_t;

  // count >= limit, with the limit clamped to what the counter can hold
  function automatic logic cnt_ge(count_t c, logic [31:0] lim);
    logic [32:0] eff;
    eff = (33'(lim) > 33'(CNT_MAX)) ? 33'(CNT_MAX) : 33'(lim);
    return 33'(c) >= eff;
  endfunction

endpackage

// ----- src/uer_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_cfg
// configuration register file, written by index
// ----------------------------------------------------------------------------
module uer_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [uer_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  output uer_pkg::cfg_t                     cfg_o
);

  uer_pkg::cfg_t cfg_r;
  uer_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (uer_pkg::cfg_idx_t'(cfg_idx))
        uer_pkg::CFG_PRE_LOW:    cfg_nxt.pre_low_ticks    = cfg_wdata[15:0];
        uer_pkg::CFG_TRIGGER:    cfg_nxt.trigger_ticks    = cfg_wdata[15:0];
        uer_pkg::CFG_WAIT_LIMIT: cfg_nxt.echo_wait_limit  = cfg_wdata[16:0];
        uer_pkg::CFG_HIGH_LIMIT: cfg_nxt.echo_high_limit  = cfg_wdata[16:0];
        uer_pkg::CFG_MAX_DIST:   cfg_nxt.max_distance     = cfg_wdata[9:0];
        uer_pkg::CFG_THRESHOLD:  cfg_nxt.change_threshold = cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pre_low_ticks    <= 16'd2;
      cfg_r.trigger_ticks    <= 16'd10;
      cfg_r.echo_wait_limit  <= 17'd10000;
      cfg_r.echo_high_limit  <= 17'd60000;
      cfg_r.max_distance     <= 10'd400;
      cfg_r.change_threshold <= 10'd5;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ----- src/uer_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_core
// ranging sequencer: advances one tick per step and forms the result beat
// ----------------------------------------------------------------------------
module uer_core (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  uer_pkg::in_item_t  item,
  input  uer_pkg::cfg_t      cfg,
  output uer_pkg::out_item_t res
);

  uer_pkg::phase_t phase_r, phase_nxt;
  uer_pkg::count_t cnt_r, cnt_nxt;
  uer_pkg::frac_t  frac_r, frac_nxt;
  uer_pkg::dist_t  dist_r, dist_nxt;
  logic [9:0]      ref_r, ref_nxt;

  logic            trig;
  logic            done;
  uer_pkg::status_t st;
  logic [9:0]      dist_out;
  logic            chg;

  // next state: phases whose length is used up fall through within the tick
  always_comb begin
    logic [uer_pkg::FRAC_BITS:0] frac_sum;
    logic [9:0]      d;
    logic [9:0]      diff;
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    frac_nxt  = frac_r;
    dist_nxt  = dist_r;
    ref_nxt   = ref_r;
    trig      = 1'b0;
    done      = 1'b0;
    st        = uer_pkg::ST_OK;
    dist_out  = '0;
    chg       = 1'b0;
    frac_sum  = '0;
    d         = '0;
    diff      = '0;

    if (phase_nxt == uer_pkg::PH_IDLE && item.kind) begin
      phase_nxt = uer_pkg::PH_PRE_LOW;
      cnt_nxt   = '0;
    end
    if (phase_nxt == uer_pkg::PH_PRE_LOW) begin
      if (uer_pkg::cnt_ge(cnt_nxt, 32'(cfg.pre_low_ticks))) begin
        phase_nxt = uer_pkg::PH_TRIG;
        cnt_nxt   = '0;
      end else begin
        cnt_nxt = cnt_nxt + uer_pkg::count_t'(1);
      end
    end
    if (phase_nxt == uer_pkg::PH_TRIG) begin
      if (uer_pkg::cnt_ge(cnt_nxt, 32'(cfg.trigger_ticks))) begin
        phase_nxt = uer_pkg::PH_WAIT;
        cnt_nxt   = '0;
      end else begin
        trig    = 1'b1;
        cnt_nxt = cnt_nxt + uer_pkg::count_t'(1);
      end
    end
    if (phase_nxt == uer_pkg::PH_WAIT) begin
      if (item.echo_level) begin
        phase_nxt = uer_pkg::PH_MEAS;
        cnt_nxt   = '0;
        frac_nxt  = '0;
        dist_nxt  = '0;
      end else if (uer_pkg::cnt_ge(cnt_nxt, 32'(cfg.echo_wait_limit))) begin
        phase_nxt = uer_pkg::PH_IDLE;
        cnt_nxt   = '0;
        done      = 1'b1;
        st        = uer_pkg::ST_NO_ECHO;
      end else begin
        cnt_nxt = cnt_nxt + uer_pkg::count_t'(1);
      end
    end
    if (phase_nxt == uer_pkg::PH_MEAS) begin
      if (item.echo_level) begin
        if (uer_pkg::cnt_ge(cnt_nxt, 32'(cfg.echo_high_limit))) begin
          phase_nxt = uer_pkg::PH_IDLE;
          cnt_nxt   = '0;
          done      = 1'b1;
          st        = uer_pkg::ST_TOO_LONG;
        end else begin
          cnt_nxt = cnt_nxt + uer_pkg::count_t'(1);
          // running floor(width*17/1000): carry a whole cm past the fraction
          frac_sum = (uer_pkg::FRAC_BITS + 1)'(frac_nxt) +
                     (uer_pkg::FRAC_BITS + 1)'(uer_pkg::CM_NUM);
          if (frac_sum >= (uer_pkg::FRAC_BITS + 1)'(uer_pkg::CM_DEN)) begin
            frac_nxt = uer_pkg::frac_t'(frac_sum -
                                        (uer_pkg::FRAC_BITS + 1)'(uer_pkg::CM_DEN));
            dist_nxt = dist_nxt + uer_pkg::dist_t'(1);
          end else begin
            frac_nxt = uer_pkg::frac_t'(frac_sum);
          end
        end
      end else begin
        d = (dist_nxt > uer_pkg::dist_t'(cfg.max_distance)) ? cfg.max_distance
                                                             : dist_nxt[9:0];
        phase_nxt = uer_pkg::PH_IDLE;
        cnt_nxt   = '0;
        done      = 1'b1;
        dist_out  = d;
        diff      = (d >= ref_r) ? (d - ref_r) : (ref_r - d);
        if (diff >= cfg.change_threshold) begin
          chg     = 1'b1;
          ref_nxt = d;
        end
      end
    end
  end

  // result beat
  always_comb begin
    res.trigger_level = trig;
    res.busy_res      = (phase_nxt != uer_pkg::PH_IDLE);
    res.done_res      = done;
    res.status        = st;
    res.range_cm      = dist_out;
    res.changed       = chg;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= uer_pkg::PH_IDLE;
      cnt_r   <= '0;
      frac_r  <= '0;
      dist_r  <= '0;
      ref_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      cnt_r   <= cnt_nxt;
      frac_r  <= frac_nxt;
      dist_r  <= dist_nxt;
      ref_r   <= ref_nxt;
    end
  end

endmodule

// ----- src/ultrasonic_echo_ranger.sv -----
`timescale 1ns / 1ps
// path: an accepted beat is held in the input register, passes through the
// sequencer into the result register and is offered to the receiver from there
// throughput: one tick beat per clock while out_stall is low, bounded by the single
// sequencer pass between the input register and the result register
// reset: synchronous active-low rst_n; sequencer idle, counters and reference
// distance zero, registers at their documented defaults, both registers empty
// ----------------------------------------------------------------------------
// ultrasonic_echo_ranger
// trigger/echo ranging controller driven by one microsecond tick per beat
// ----------------------------------------------------------------------------
module ultrasonic_echo_ranger (
  input  logic                              clk,
  input  logic                              rst_n,
  // tick beats
  input  logic                              in_vld,
  output logic                              in_stall,
  input  uer_pkg::in_item_t                 in_data,
  // result beats
  output logic                              out_vld,
  input  logic                              out_stall,
  output uer_pkg::out_item_t                out_data,
  // register writes
  input  logic                              cfg_we,
  input  logic [uer_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [uer_pkg::CFG_DATA_BITS-1:0] cfg_wdata
);

  uer_pkg::cfg_t      cfg;
  uer_pkg::out_item_t res;

  // input register
  logic               in_vld_r, in_vld_nxt;
  uer_pkg::in_item_t  in_data_r;
  // result register
  logic               out_vld_r, out_vld_nxt;
  uer_pkg::out_item_t out_data_r;

  logic advance;
  logic in_take;

  // the held beat moves on whenever the result register is empty or drains
  assign advance  = in_vld_r && (!out_vld_r || !out_stall);
  // input register frees up when its beat advances, so ticks flow every cycle while out_stall is low
  assign in_stall = in_vld_r && !advance;
  assign in_take  = in_vld && !in_stall;

  always_comb begin
    in_vld_nxt = in_take ? 1'b1 : (advance ? 1'b0 : in_vld_r);
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // payload registers carry no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  uer_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // sequencer state steps only when a tick leaves the input register
  uer_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (in_data_r),
    .cfg   (cfg),
    .res   (res)
  );

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

// ----- src/uer_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uer_checker
// port-level checks on result beats, bound to the top level
// ----------------------------------------------------------------------------
module uer_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_vld,
  input logic               out_stall,
  input uer_pkg::out_item_t out_data
);

  // a stalled result beat stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_stall |=> out_vld && $stable(out_data))
    else $error("result beat changed while stalled");

  // nothing reported unless a measurement finished
  a_idle_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && !out_data.done_res |->
      out_data.status == uer_pkg::ST_OK && out_data.range_cm == 10'd0 &&
      !out_data.changed)
    else $error("result fields set without a finish");

  // changed only on a good finish
  a_changed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_data.changed |->
      out_data.done_res && out_data.status == uer_pkg::ST_OK)
    else $error("changed without a good finish");

  // a finish tick ends the measurement with the trigger low
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_data.done_res |-> !out_data.busy_res && !out_data.trigger_level)
    else $error("finish tick still busy or triggering");

  // trigger is only driven inside a measurement
  a_trig_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld && out_data.trigger_level |-> out_data.busy_res)
    else $error("trigger high while idle");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_vld   (out_vld),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- verif/ranger_tb_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ranger_tb_pkg
// tick-accurate ranging predictor and reading checker for the echo ranger bench
// ----------------------------------------------------------------------------
package ranger_tb_pkg;
  import uer_pkg::*;

  class ranging_scoreboard;
    cfg_t       regs;
    phase_t     seq_phase;
    count_t     ticks;
    logic [9:0] ref_cm;
    out_item_t  readings_due[$];
    int         mismatches;
    int         readings_seen;

    function new();
      regs.pre_low_ticks    = 16'd2;
      regs.trigger_ticks    = 16'd10;
      regs.echo_wait_limit  = 17'd10000;
      regs.echo_high_limit  = 17'd60000;
      regs.max_distance     = 10'd400;
      regs.change_threshold = 10'd5;
      seq_phase     = PH_IDLE;
      ticks         = '0;
      ref_cm        = '0;
      mismatches    = 0;
      readings_seen = 0;
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function void set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
      case (idx)
        CFG_PRE_LOW:    regs.pre_low_ticks    = val[15:0];
        CFG_TRIGGER:    regs.trigger_ticks    = val[15:0];
        CFG_WAIT_LIMIT: regs.echo_wait_limit  = val[16:0];
        CFG_HIGH_LIMIT: regs.echo_high_limit  = val[16:0];
        CFG_MAX_DIST:   regs.max_distance     = val[9:0];
        CFG_THRESHOLD:  regs.change_threshold = val[9:0];
        default: ;
      endcase
    endfunction

    // limits saturate at what the tick counter can reach
    function bit reached(count_t c, logic [16:0] lim);
      longint eff;
      eff = (longint'(lim) > CNT_MAX) ? CNT_MAX : longint'(lim);
      return longint'(c) >= eff;
    endfunction

    function bit busy();
      return seq_phase != PH_IDLE;
    endfunction

    // one tick beat: phases that run out hand over within the same tick
    function void add_tick(in_item_t beat);
      out_item_t   due;
      int unsigned cm;
      int unsigned moved;
      due = '0;
      if (seq_phase == PH_IDLE && beat.kind) begin
        seq_phase = PH_PRE_LOW;
        ticks = '0;
      end
      if (seq_phase == PH_PRE_LOW) begin
        if (reached(ticks, 17'(regs.pre_low_ticks))) begin
          seq_phase = PH_TRIG;
          ticks = '0;
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      if (seq_phase == PH_TRIG) begin
        if (reached(ticks, 17'(regs.trigger_ticks))) begin
          seq_phase = PH_WAIT;
          ticks = '0;
        end else begin
          due.trigger_level = 1'b1;
          ticks = ticks + 1'b1;
        end
      end
      if (seq_phase == PH_WAIT) begin
        if (beat.echo_level) begin
          seq_phase = PH_MEAS;
          ticks = '0;
        end else if (reached(ticks, regs.echo_wait_limit)) begin
          seq_phase = PH_IDLE;
          ticks = '0;
          due.done_res = 1'b1;
          due.status = ST_NO_ECHO;
        end else begin
          ticks = ticks + 1'b1;
        end
      end
      if (seq_phase == PH_MEAS) begin
        if (beat.echo_level) begin
          if (reached(ticks, regs.echo_high_limit)) begin
            seq_phase = PH_IDLE;
            ticks = '0;
            due.done_res = 1'b1;
            due.status = ST_TOO_LONG;
          end else begin
            ticks = ticks + 1'b1;
          end
        end else begin
          cm = (32'(ticks) * CM_NUM) / CM_DEN;
          if (cm > regs.max_distance) cm = 32'(regs.max_distance);
          moved = (cm >= ref_cm) ? cm - ref_cm : ref_cm - cm;
          seq_phase = PH_IDLE;
          ticks = '0;
          due.done_res = 1'b1;
          due.range_cm = cm[9:0];
          if (moved >= regs.change_threshold) begin
            due.changed = 1'b1;
            ref_cm = cm[9:0];
          end
        end
      end
      due.busy_res = (seq_phase != PH_IDLE);
      readings_due.push_back(due);
    endfunction

    task compare(string field, logic [9:0] got, logic [9:0] want);
      if (got !== want)
        report($sformatf("reading %0d %s got %0d want %0d", readings_seen, field, got, want));
    endtask

    task check_reading(out_item_t got);
      out_item_t want;
      if (readings_due.size() == 0) begin
        report($sformatf("reading beat %0d with none pending", readings_seen));
        return;
      end
      want = readings_due.pop_front();
      compare("trigger_level", 10'(got.trigger_level), 10'(want.trigger_level));
      compare("busy_res", 10'(got.busy_res), 10'(want.busy_res));
      compare("done_res", 10'(got.done_res), 10'(want.done_res));
      compare("status", 10'(got.status), 10'(want.status));
      compare("range_cm", got.range_cm, want.range_cm);
      compare("changed", 10'(got.changed), 10'(want.changed));
      readings_seen++;
    endtask

    task flush();
      if (readings_due.size() != 0)
        report($sformatf("%0d readings never arrived", readings_due.size()));
    endtask
  endclass

endpackage

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// drives the echo ranger one microsecond tick per beat through directed and
// random ranging sequences across several register settings, with random
// gaps and stalls on both sides, and checks every reading against a
// tick-accurate prediction
// ----------------------------------------------------------------------------
module tb_top;
  import uer_pkg::*;
  import ranger_tb_pkg::*;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_BITS-1:0] CFG_UNUSED = 3'd7;
  localparam int RANDOM_BEATS = 750;
  // long receiver hold-off, started once this many readings are in
  localparam int HOLD_AT   = 600;
  localparam int LONG_HOLD = 150;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_vld;
  logic                     in_stall;
  in_item_t                 in_data;
  logic                     out_vld;
  logic                     out_stall;
  out_item_t                out_data;
  logic                     cfg_we;
  logic [CFG_IDX_BITS-1:0]  cfg_idx;
  logic [CFG_DATA_BITS-1:0] cfg_wdata;

  ranging_scoreboard board = new();
  bit                no_idle;
  bit                hold_done;
  int                beats_sent;

  ultrasonic_echo_ranger dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (in_vld),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_vld   (out_vld),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // one tick beat: optional gap, then hold until taken
  task automatic send_tick(input logic start, input logic echo);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      in_vld <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_vld  <= 1'b1;
    in_data <= '{kind: start, echo_level: echo};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // beat taken at this edge, predict its reading
    board.add_tick(in_data);
    beats_sent++;
  endtask

  // quiet ticks until the sequencer is back in idle
  task automatic run_out_sequence();
    while (board.busy()) send_tick(1'b0, 1'b0);
  endtask

  // drop valid and let every pending reading come out
  task automatic quiesce();
    @(negedge clk);
    in_vld <= 1'b0;
    while (board.readings_due.size() != 0) @(posedge clk);
    // then idle edges for the result register
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    board.set_reg(idx, val);
  endtask

  task automatic write_regs(input int unsigned pre, input int unsigned trig,
                            input int unsigned wlim, input int unsigned hlim,
                            input int unsigned maxd, input int unsigned thr);
    write_reg(CFG_PRE_LOW, CFG_DATA_BITS'(pre));
    write_reg(CFG_TRIGGER, CFG_DATA_BITS'(trig));
    write_reg(CFG_WAIT_LIMIT, CFG_DATA_BITS'(wlim));
    write_reg(CFG_HIGH_LIMIT, CFG_DATA_BITS'(hlim));
    write_reg(CFG_MAX_DIST, CFG_DATA_BITS'(maxd));
    write_reg(CFG_THRESHOLD, CFG_DATA_BITS'(thr));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // start beat, echo noise through the trigger phases, some low ticks,
  // an echo pulse of the given width and one closing low tick
  task automatic run_measurement(input int lows, input int highs,
                                 input bit finish_start, input bit noisy);
    int   lead;
    int   total;
    logic start;
    logic echo;
    lead  = int'(board.regs.pre_low_ticks) + int'(board.regs.trigger_ticks);
    total = lead + lows + highs + 1;
    for (int i = 0; i < total; i++) begin
      if (i < lead) echo = 1'($urandom_range(0, 1));
      else echo = (i >= lead + lows) && (i < total - 1);
      // a start on the finishing tick must be ignored
      start = (i == 0) || (finish_start && i == total - 1);
      // broken sequences: stray starts and echo glitches
      if (noisy && $urandom_range(0, 15) == 0) begin
        start = ~start;
        echo  = ~echo;
      end
      send_tick(start, echo);
    end
  endtask

  // one random register setting and a handful of sequences under it
  task automatic random_phase();
    int wait_lim;
    int high_lim;
    int roll;
    int lows;
    int highs;
    int k;
    run_out_sequence();
    quiesce();
    write_regs($urandom_range(0, 3), $urandom_range(0, 12), $urandom_range(1, 30),
               $urandom_range(0, 1) ? $urandom_range(1, 40) : $urandom_range(150, 400),
               $urandom_range(0, 6), $urandom_range(0, 3));
    wait_lim = int'(board.regs.echo_wait_limit);
    high_lim = int'(board.regs.echo_high_limit);
    repeat (4) begin
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        // loose ticks with random start and echo
        repeat ($urandom_range(1, 8))
          send_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end else begin
        // around the no-echo limit, or well inside it
        if (roll < 25) lows = wait_lim + $urandom_range(0, 2);
        else lows = $urandom_range(0, wait_lim > 20 ? 20 : wait_lim);
        if (roll >= 25 && roll < 35 && high_lim <= 40) begin
          // around the too-long limit
          highs = high_lim + $urandom_range(0, 2);
        end else if (roll < 65) begin
          // widths next to a whole-centimetre step
          k = $urandom_range(1, 6);
          highs = (CM_DEN * k + CM_NUM - 1) / CM_NUM - 1 + $urandom_range(0, 2);
        end else begin
          highs = $urandom_range(1, high_lim > 300 ? 300 : high_lim);
        end
        run_out_sequence();
        run_measurement(lows, highs, $urandom_range(0, 3) == 0, roll >= 85);
      end
    end
  endtask

  // result side: random stall per beat, one long hold-off
  initial begin : result_sink
    int hold;
    out_stall = 1'b0;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 4);
      if (!hold_done && board.readings_seen >= HOLD_AT) begin
        // sender keeps offering beats, so the block backs up into in_stall
        hold = LONG_HOLD;
        hold_done = 1'b1;
      end
      @(negedge clk);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(rst_n && out_vld)) @(posedge clk);
    end
  end

  // reading beats are checked at the edge that takes them
  always @(posedge clk) begin
    if (rst_n && out_vld && !out_stall) board.check_reading(out_data);
  end

  initial begin : stimulus
    int mark;
    rst_n      = 1'b0;
    in_vld     = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_idx    = '0;
    cfg_wdata  = '0;
    no_idle    = 1'b0;
    hold_done  = 1'b0;
    beats_sent = 0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: short echo right after the trigger pulse
    run_measurement(0, 3, 1'b0, 1'b0);

    // zero lengths and zero limits, every wait gives up on its first tick;
    // bit 16 written to a 16-bit register is dropped
    run_out_sequence();
    quiesce();
    write_reg(CFG_UNUSED, 17'h1ffff);
    write_regs(32'h10000, 0, 0, 0, 0, 0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);

    // one-tick phases, start while busy, start on the finishing tick,
    // zero threshold so the good finish always flags a change
    quiesce();
    write_regs(1, 1, 2, 3, 1023, 0);
    send_tick(1'b1, 1'b0);
    send_tick(1'b1, 1'b1);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b0);
    send_tick(1'b0, 1'b1);
    send_tick(1'b0, 1'b1);
    send_tick(1'b1, 1'b0);

    mark = beats_sent;
    while (beats_sent - mark < RANDOM_BEATS) random_phase();

    // largest limits, back to back, an echo whose distance runs past the cap
    run_out_sequence();
    quiesce();
    write_regs(0, 1, 17'h1ffff, 17'h1ffff, 1, 1023);
    no_idle = 1'b1;
    run_measurement(3, 120, 1'b1, 1'b0);
    no_idle = 1'b0;
    run_out_sequence();

    quiesce();
    repeat (10) @(posedge clk);
    board.flush();
    if (board.mismatches == 0) begin
      $display("PASS ultrasonic_echo_ranger");
    end else begin
      $display("FAIL ultrasonic_echo_ranger");
    end
    $finish;
  end

  // hang guard, far past the slowest run
  initial begin : watchdog
    #40_000_000;
    $display("FAIL ultrasonic_echo_ranger");
    $finish;
  end

endmodule

// ----- filelist.f -----
src/uer_pkg.sv
src/uer_cfg.sv
src/uer_core.sv
src/ultrasonic_echo_ranger.sv
src/uer_checker.sv
verif/ranger_tb_pkg.sv
verif/tb_top.sv
